// File: hdl/mrps_pkg.sv
// ----------------------------------------------------------------------------
// mrps_pkg
// Types and constants shared by the motor ramp profile sequencer files.
// ----------------------------------------------------------------------------
`default_nettype none

package mrps_pkg;

    // Sequencer phases, one-hot encoded.
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_UP   = 6'b000010,
        PH_HOLD = 6'b000100,
        PH_DOWN = 6'b001000,
        PH_CONT = 6'b010000,
        PH_SOFT = 6'b100000
    } phase_t;

    // Phase codes as reported on the result channel.
    localparam logic [2:0] PHASE_CODE_IDLE = 3'd0;
    localparam logic [2:0] PHASE_CODE_UP   = 3'd1;
    localparam logic [2:0] PHASE_CODE_HOLD = 3'd2;
    localparam logic [2:0] PHASE_CODE_DOWN = 3'd3;
    localparam logic [2:0] PHASE_CODE_CONT = 3'd4;
    localparam logic [2:0] PHASE_CODE_SOFT = 3'd5;

    // Drive direction codes.
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // Configuration register indexes (word address).
    localparam logic [1:0] REG_RAMP_STEP = 2'd0;
    localparam logic [1:0] REG_HOLD      = 2'd1;
    localparam logic [1:0] REG_MAX_DUTY  = 2'd2;

    // Register widths and reset values.
    localparam int unsigned RAMP_STEP_W = 10;
    localparam int unsigned HOLD_W      = 16;
    localparam int unsigned MAX_DUTY_W  = 8;

    localparam logic [RAMP_STEP_W-1:0] RAMP_STEP_RST = 10'd9;
    localparam logic [HOLD_W-1:0]      HOLD_RST      = 16'd10000;
    localparam logic [MAX_DUTY_W-1:0]  MAX_DUTY_RST  = 8'd255;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

endpackage

`default_nettype wire

// File: hdl/mrps_ifs.sv
// ----------------------------------------------------------------------------
// mrps_ifs
// Valid/ready channels of the sequencer: button tick in, profile result out.
// ----------------------------------------------------------------------------
`default_nettype none

// One tick with four button levels.
interface mrps_btn_if;
    logic valid;
    logic ready;
    logic btn_a;
    logic btn_b;
    logic btn_c;
    logic btn_d;

    modport source (output valid, output btn_a, output btn_b, output btn_c,
                    output btn_d, input ready);
    modport sink   (input valid, input btn_a, input btn_b, input btn_c,
                    input btn_d, output ready);
endinterface

// One result per tick: duty, direction and phase.
interface mrps_res_if #(
    parameter int unsigned DUTY_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] duty;
    logic [1:0]           drive_dir;
    logic [2:0]           phase;

    modport source (output valid, output duty, output drive_dir, output phase,
                    input ready);
    modport sink   (input valid, input duty, input drive_dir, input phase,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/motor_ramp_profile_sequencer_core.sv
// ----------------------------------------------------------------------------
// motor_ramp_profile_sequencer_core
// Trapezoidal motor speed profile with soft start and soft stop, one tick
// per transfer, with an APB-style register port.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                       Transfer when
//  -------   ---------  ----------------------------  --------------------
//  buttons   in         btn_a, btn_b, btn_c, btn_d    valid && ready
//  profile   out        duty, drive_dir, phase        valid && ready
//  APB       in/out     ramp_step_ms, hold_ms, max_duty psel&penable&pwrite
//
// Each tick is processed in one combinational pass that computes the state
// update and the result, and the result is registered, so one tick is accepted
// every clock while the result register is not stalled, its result in the next cycle.
// A tick is accepted while the result register is empty or being drained.
// Reset returns the sequencer to idle with the documented register values.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_ramp_profile_sequencer_core #(
    parameter int unsigned DUTY_BITS  = 8,
    parameter int unsigned TIMER_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    mrps_btn_if.sink                             buttons,
    mrps_res_if.source                           profile,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mrps_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mrps_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mrps_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    // Tick counter must hold both the timer range and a step length minus one.
    localparam int unsigned TC_W  = (TIMER_BITS > mrps_pkg::RAMP_STEP_W) ?
                                    TIMER_BITS : mrps_pkg::RAMP_STEP_W;
    localparam int unsigned CMP_W = (TC_W > mrps_pkg::HOLD_W) ? TC_W : mrps_pkg::HOLD_W;
    localparam logic [TC_W-1:0] TC_MAX = TC_W'({TIMER_BITS{1'b1}});

    // Configuration registers.
    logic [mrps_pkg::RAMP_STEP_W-1:0] ramp_step_reg;
    logic [mrps_pkg::HOLD_W-1:0]      hold_reg;
    logic [mrps_pkg::MAX_DUTY_W-1:0]  max_duty_reg;

    // Sequencer state.
    mrps_pkg::phase_t     phase_reg, phase_next;
    logic [DUTY_BITS-1:0] duty_reg, duty_next;
    logic [1:0]           dir_reg, dir_next;
    logic                 auto_stop_reg, auto_stop_next;
    logic [TC_W-1:0]      tick_reg, tick_next;

    // Result register.
    logic                 res_valid_reg;
    logic [DUTY_BITS-1:0] res_duty_reg, res_duty_next;
    logic [1:0]           res_dir_reg, res_dir_next;
    logic [2:0]           res_phase_reg, res_phase_next;

    logic in_xfer;
    logic cfg_wr;

    // APB port: always ready, writes in the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_step_reg <= mrps_pkg::RAMP_STEP_RST;
            hold_reg      <= mrps_pkg::HOLD_RST;
            max_duty_reg  <= mrps_pkg::MAX_DUTY_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                mrps_pkg::REG_RAMP_STEP: ramp_step_reg <= pwdata[mrps_pkg::RAMP_STEP_W-1:0];
                mrps_pkg::REG_HOLD:      hold_reg      <= pwdata[mrps_pkg::HOLD_W-1:0];
                mrps_pkg::REG_MAX_DUTY:  max_duty_reg  <= pwdata[mrps_pkg::MAX_DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            mrps_pkg::REG_RAMP_STEP: prdata = mrps_pkg::APB_DATA_W'(ramp_step_reg);
            mrps_pkg::REG_HOLD:      prdata = mrps_pkg::APB_DATA_W'(hold_reg);
            mrps_pkg::REG_MAX_DUTY:  prdata = mrps_pkg::APB_DATA_W'(max_duty_reg);
            default:                 prdata = '0;
        endcase
    end

    // Handshake: accept while the result register is free or draining.
    assign buttons.ready = !res_valid_reg || profile.ready;
    assign in_xfer       = buttons.valid && buttons.ready;

    // One tick of the profile sequencer.
    always_comb
    begin
        logic [mrps_pkg::RAMP_STEP_W-1:0] step_len;
        logic [DUTY_BITS-1:0]             max_trunc;
        logic [DUTY_BITS-1:0]             top_duty;
        logic [TC_W-1:0]                  tick_inc;
        logic                             stoppable;

        step_len  = (ramp_step_reg == '0) ? mrps_pkg::RAMP_STEP_W'(1) : ramp_step_reg;
        max_trunc = DUTY_BITS'(max_duty_reg);
        top_duty  = (max_trunc == '0) ? DUTY_BITS'(1) : max_trunc;

        phase_next     = phase_reg;
        duty_next      = duty_reg;
        dir_next       = dir_reg;
        auto_stop_next = auto_stop_reg;
        tick_next      = tick_reg;

        // Start of a run from idle, A over B over C.
        if (phase_reg == mrps_pkg::PH_IDLE &&
            (buttons.btn_a || buttons.btn_b || buttons.btn_c))
        begin
            phase_next     = mrps_pkg::PH_UP;
            duty_next      = '0;
            tick_next      = '0;
            dir_next       = buttons.btn_a ? mrps_pkg::DIR_REV : mrps_pkg::DIR_FWD;
            auto_stop_next = buttons.btn_a || buttons.btn_b;
        end

        // Soft stop request during any running phase.
        stoppable = (phase_next == mrps_pkg::PH_UP)   || (phase_next == mrps_pkg::PH_HOLD) ||
                    (phase_next == mrps_pkg::PH_DOWN) || (phase_next == mrps_pkg::PH_CONT);
        if (buttons.btn_d && stoppable)
        begin
            phase_next = mrps_pkg::PH_SOFT;
            tick_next  = (duty_next == '0) ? TC_W'(step_len - 1'b1) : '0;
        end

        // The result describes the tick as it is executed.
        res_duty_next = duty_next;
        res_dir_next  = (duty_next != '0) ? dir_next : mrps_pkg::DIR_STOP;
        case (phase_next)
            mrps_pkg::PH_IDLE: res_phase_next = mrps_pkg::PHASE_CODE_IDLE;
            mrps_pkg::PH_UP:   res_phase_next = mrps_pkg::PHASE_CODE_UP;
            mrps_pkg::PH_HOLD: res_phase_next = mrps_pkg::PHASE_CODE_HOLD;
            mrps_pkg::PH_DOWN: res_phase_next = mrps_pkg::PHASE_CODE_DOWN;
            mrps_pkg::PH_CONT: res_phase_next = mrps_pkg::PHASE_CODE_CONT;
            mrps_pkg::PH_SOFT: res_phase_next = mrps_pkg::PHASE_CODE_SOFT;
            default:           res_phase_next = mrps_pkg::PHASE_CODE_IDLE;
        endcase

        // Saturating tick count.
        tick_inc = (tick_next < TC_MAX) ? tick_next + 1'b1 : tick_next;

        case (phase_next)
            mrps_pkg::PH_UP:
            begin
                tick_next = tick_inc;
                if (CMP_W'(tick_inc) >= CMP_W'(step_len))
                begin
                    tick_next = '0;
                    if (duty_next >= top_duty)
                    begin
                        duty_next = top_duty;
                        if (!auto_stop_next)
                            phase_next = mrps_pkg::PH_CONT;
                        else if (hold_reg == '0)
                            phase_next = mrps_pkg::PH_DOWN;
                        else
                            phase_next = mrps_pkg::PH_HOLD;
                    end
                    else
                    begin
                        duty_next = duty_next + 1'b1;
                    end
                end
            end
            mrps_pkg::PH_HOLD:
            begin
                tick_next = tick_inc;
                if (CMP_W'(tick_inc) >= CMP_W'(hold_reg))
                begin
                    tick_next  = '0;
                    phase_next = mrps_pkg::PH_DOWN;
                end
            end
            mrps_pkg::PH_DOWN, mrps_pkg::PH_SOFT:
            begin
                tick_next = tick_inc;
                if (CMP_W'(tick_inc) >= CMP_W'(step_len))
                begin
                    tick_next = '0;
                    if (duty_next == '0)
                    begin
                        phase_next     = mrps_pkg::PH_IDLE;
                        dir_next       = mrps_pkg::DIR_STOP;
                        auto_stop_next = 1'b0;
                    end
                    else
                    begin
                        duty_next = duty_next - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // State update on each accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mrps_pkg::PH_IDLE;
            duty_reg      <= '0;
            dir_reg       <= mrps_pkg::DIR_STOP;
            auto_stop_reg <= 1'b0;
            tick_reg      <= '0;
        end
        else if (in_xfer)
        begin
            phase_reg     <= phase_next;
            duty_reg      <= duty_next;
            dir_reg       <= dir_next;
            auto_stop_reg <= auto_stop_next;
            tick_reg      <= tick_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (in_xfer)
            res_valid_reg <= 1'b1;
        else if (profile.ready)
            res_valid_reg <= 1'b0;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_duty_reg  <= res_duty_next;
            res_dir_reg   <= res_dir_next;
            res_phase_reg <= res_phase_next;
        end
    end

    assign profile.valid     = res_valid_reg;
    assign profile.duty      = res_duty_reg;
    assign profile.drive_dir = res_dir_reg;
    assign profile.phase     = res_phase_reg;

    // A direction is only reported while the motor is driven.
    a_dir_needs_duty: assert property (@(posedge clk) disable iff (!rst_n)
        profile.valid && (profile.drive_dir != mrps_pkg::DIR_STOP) |-> (profile.duty != '0))
        else $error("drive direction reported with zero duty");

    // Idle always carries zero duty and no direction.
    a_idle_is_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mrps_pkg::PH_IDLE) |-> (duty_reg == '0) &&
        (dir_reg == mrps_pkg::DIR_STOP) && !auto_stop_reg)
        else $error("idle phase with residual drive state");

    // Every accepted tick yields a result in the following cycle.
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> profile.valid)
        else $error("accepted tick produced no result");

    // Away from a ramp up and a start from idle, duty holds, drops by one level or
    // is zero after each accepted tick.
    a_duty_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (phase_reg != mrps_pkg::PH_UP) && (phase_reg != mrps_pkg::PH_IDLE) |=>
        (duty_reg == $past(duty_reg)) || (duty_reg == $past(duty_reg) - 1'b1) ||
        (duty_reg == '0))
        else $error("duty jumped outside a ramp up");

endmodule

`default_nettype wire
